### rtl/bdlf_pkg.sv
// ----------------------------------------------------------------------------
// bdlf_pkg
// Shared types and codes for the HDMV LPCM packet framer.
// ----------------------------------------------------------------------------
package bdlf_pkg;

    // Width of the configuration data port (widest register)
    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 3;
    // Disc layout never has more than eight slots
    localparam int SLOT_CNT_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_INPUT_CHANNELS = 3'd0,
        REG_RATE_SELECT    = 3'd1,
        REG_DEPTH_SELECT   = 3'd2,
        REG_LITTLE_ENDIAN  = 3'd3,
        REG_SLOT_MAP       = 3'd4
    } reg_index_t;

    // Channel assignment codes
    localparam logic [3:0] CA_STEREO = 4'd3;
    localparam logic [3:0] CA_SIX    = 4'd9;
    localparam logic [3:0] CA_EIGHT  = 4'd11;

    // Sampling rate codes
    localparam logic [3:0] SR_48K  = 4'd1;
    localparam logic [3:0] SR_96K  = 4'd4;
    localparam logic [3:0] SR_192K = 4'd5;

    // Depth codes
    localparam logic [1:0] BC_16BIT = 2'd1;
    localparam logic [1:0] BC_24BIT = 2'd3;

    // Byte counts on the output
    localparam logic [2:0] NB_HEADER = 3'd4;
    localparam logic [2:0] NB_16BIT  = 3'd2;
    localparam logic [2:0] NB_24BIT  = 3'd3;

    // Reset values of the registers
    localparam logic [3:0]  RST_INPUT_CHANNELS = 4'd2;
    localparam logic [1:0]  RST_RATE_SELECT    = 2'd0;
    localparam logic        RST_DEPTH_SELECT   = 1'b0;
    localparam logic        RST_LITTLE_ENDIAN  = 1'b1;
    localparam logic [31:0] RST_SLOT_MAP       = 32'h7654_3210;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [3:0]  input_channels;
        logic [1:0]  rate_select;
        logic        depth_select;
        logic        little_endian;
        logic [31:0] slot_map;
    } cfg_t;

    // Disc layout derived from the effective channel count
    typedef struct packed {
        logic [3:0] slots;
        logic [3:0] assign_code;
    } layout_t;

endpackage

### rtl/bdlf_if.sv
// ----------------------------------------------------------------------------
// bdlf_if
// Valid/ready stream interfaces for PCM samples in and framed words out.
// ----------------------------------------------------------------------------
interface bdlf_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] sample_raw;
    logic        packet_start;
    logic [8:0]  packet_samples;

    modport source (output valid, output sample_raw, output packet_start,
                    output packet_samples, input ready);
    modport sink   (input valid, input sample_raw, input packet_start,
                    input packet_samples, output ready);
endinterface

interface bdlf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_data;
    logic [2:0]  out_bytes;
    logic        is_header;
    logic        last_of_run;

    modport source (output valid, output out_data, output out_bytes,
                    output is_header, output last_of_run, input ready);
    modport sink   (input valid, input out_data, input out_bytes,
                    input is_header, input last_of_run, output ready);
endinterface

### rtl/bdlf_frame_store.sv
// ----------------------------------------------------------------------------
// bdlf_frame_store
// One-port-write, one-port-read frame memory, registered read data.
// ----------------------------------------------------------------------------
module bdlf_frame_store #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [23:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [23:0]   rdata
);

    logic [23:0] mem [DEPTH];
    logic [23:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bdlf_formatter.sv
// ----------------------------------------------------------------------------
// bdlf_formatter
// Builds the packet header word and the sample word in the selected byte order.
// ----------------------------------------------------------------------------
module bdlf_formatter
    import bdlf_pkg::*;
(
    input  cfg_t        cfg,
    input  layout_t     layout,
    input  logic [8:0]  frames,
    input  logic [23:0] sample,
    input  logic        silent,
    output logic [31:0] header_word,
    output logic [31:0] sample_word,
    output logic [2:0]  sample_bytes
);

    logic [4:0]  slot_bytes;
    logic [13:0] payload;
    logic [3:0]  rate_code;
    logic [1:0]  depth_code;

    // Bytes per frame: slots times sample width
    always_comb
    begin
        if (cfg.depth_select)
        begin
            slot_bytes = 5'(layout.slots * 3);
        end
        else
        begin
            slot_bytes = 5'(layout.slots * 2);
        end
    end

    assign payload = 14'(frames * slot_bytes);

    // Rate code, the unused select acts as 192k
    always_comb
    begin
        unique case (cfg.rate_select)
            2'd0:    rate_code = SR_48K;
            2'd1:    rate_code = SR_96K;
            default: rate_code = SR_192K;
        endcase
    end

    assign depth_code  = cfg.depth_select ? BC_24BIT : BC_16BIT;
    assign header_word = {2'b00, payload, layout.assign_code, rate_code, depth_code, 6'b0};

    // Sample byte order; swap keeps the raw value masked to the depth
    always_comb
    begin
        sample_bytes = cfg.depth_select ? NB_24BIT : NB_16BIT;
        if (silent)
        begin
            sample_word = '0;
        end
        else if (cfg.depth_select)
        begin
            sample_word = cfg.little_endian
                        ? {8'b0, sample}
                        : {8'b0, sample[7:0], sample[15:8], sample[23:16]};
        end
        else
        begin
            sample_word = cfg.little_endian
                        ? {16'b0, sample[15:0]}
                        : {16'b0, sample[7:0], sample[15:8]};
        end
    end

endmodule

### rtl/bd_lpcm_packet_framer.sv
// ----------------------------------------------------------------------------
// bd_lpcm_packet_framer
// HDMV LPCM packet framer: interleaved PCM samples in, header and disc-order
// samples out.
// ----------------------------------------------------------------------------
// Samples enter one channel at a time and are written to a small frame memory.
// A sample flagged packet_start first produces a 4-byte header (payload
// length, assignment, rate and depth codes). The sample that completes a frame
// then produces 2, 6 or 8 output samples in slot order, each fetched from the
// frame memory through slot_map; slots mapped at or above the channel count
// give silence. A header is loaded in ST_HDR; each output slot passes through
// a memory read state (ST_READ) and then an output load state (ST_EMIT), the
// single read port of the frame memory setting this per-slot order. ST_HDR
// and ST_EMIT wait while the output is stalled, and the input is not ready
// again until the header and all slots are loaded. Configuration must
// only be written while the block is idle.
// ----------------------------------------------------------------------------
module bd_lpcm_packet_framer
    import bdlf_pkg::*;
#(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    bdlf_in_if.sink                pcm,
    bdlf_out_if.source             pkt
);

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [3:0] MAX_CH4 = 4'(MAX_CHANNELS);

    cfg_t    cfg_reg;
    layout_t layout;
    logic [3:0] nch;

    state_t state_reg, state_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [SLOT_CNT_W-1:0] slot_reg, slot_next;
    logic                  complete_reg, complete_next;
    logic [8:0]            frames_reg;
    logic                  silent_reg;

    logic [AW-1:0] cur_pos;
    logic          accept;
    logic          frame_done;
    logic          out_free;
    logic          load_hdr;
    logic          load_smp;
    logic          last_slot;
    logic [3:0]    slot_idx;

    logic [23:0] rd_data;
    logic [31:0] header_word;
    logic [31:0] sample_word;
    logic [2:0]  sample_bytes;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg;
    logic [2:0]  out_bytes_reg;
    logic        is_header_reg;
    logic        last_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_channels <= RST_INPUT_CHANNELS;
            cfg_reg.rate_select    <= RST_RATE_SELECT;
            cfg_reg.depth_select   <= RST_DEPTH_SELECT;
            cfg_reg.little_endian  <= RST_LITTLE_ENDIAN;
            cfg_reg.slot_map       <= RST_SLOT_MAP;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_INPUT_CHANNELS: cfg_reg.input_channels <= cfg_data[3:0];
                REG_RATE_SELECT:    cfg_reg.rate_select    <= cfg_data[1:0];
                REG_DEPTH_SELECT:   cfg_reg.depth_select   <= cfg_data[0];
                REG_LITTLE_ENDIAN:  cfg_reg.little_endian  <= cfg_data[0];
                REG_SLOT_MAP:       cfg_reg.slot_map       <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Effective channel count and disc layout
    always_comb
    begin
        if (cfg_reg.input_channels == 4'd0)
        begin
            nch = 4'd1;
        end
        else if (cfg_reg.input_channels > MAX_CH4)
        begin
            nch = MAX_CH4;
        end
        else
        begin
            nch = cfg_reg.input_channels;
        end

        if (nch <= 4'd2)
        begin
            layout.slots       = 4'd2;
            layout.assign_code = CA_STEREO;
        end
        else if (nch <= 4'd6)
        begin
            layout.slots       = 4'd6;
            layout.assign_code = CA_SIX;
        end
        else
        begin
            layout.slots       = 4'd8;
            layout.assign_code = CA_EIGHT;
        end
    end

    // Input side: packet start restarts the frame
    assign accept     = pcm.valid && pcm.ready;
    assign cur_pos    = pcm.packet_start ? '0 : pos_reg;
    assign frame_done = (4'(cur_pos) + 4'd1) >= nch;

    assign out_free  = !out_valid_reg || pkt.ready;
    assign slot_idx  = cfg_reg.slot_map[4 * slot_reg +: 4];
    assign last_slot = (4'(slot_reg) + 4'd1) == layout.slots;

    // Frame memory
    bdlf_frame_store #(
        .DEPTH (MAX_CHANNELS),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (accept),
        .waddr (cur_pos),
        .wdata (pcm.sample_raw),
        .raddr (slot_idx[AW-1:0]),
        .rdata (rd_data)
    );

    bdlf_formatter u_fmt (
        .cfg          (cfg_reg),
        .layout       (layout),
        .frames       (frames_reg),
        .sample       (rd_data),
        .silent       (silent_reg),
        .header_word  (header_word),
        .sample_word  (sample_word),
        .sample_bytes (sample_bytes)
    );

    // Sequencer: next state and outputs
    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        slot_next     = slot_reg;
        complete_next = complete_reg;
        pcm.ready     = 1'b0;
        load_hdr      = 1'b0;
        load_smp      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pcm.ready = 1'b1;
                if (pcm.valid)
                begin
                    complete_next = frame_done;
                    slot_next     = '0;
                    pos_next      = frame_done ? '0 : AW'(cur_pos + 1'b1);
                    if (pcm.packet_start)
                    begin
                        state_next = ST_HDR;
                    end
                    else if (frame_done)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_HDR:
            begin
                if (out_free)
                begin
                    load_hdr   = 1'b1;
                    state_next = complete_reg ? ST_READ : ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load_smp = 1'b1;
                    if (last_slot)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            slot_reg     <= '0;
            complete_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            slot_reg     <= slot_next;
            complete_reg <= complete_next;
        end
    end

    // Packet frame count and slot silence flag
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            frames_reg <= pcm.packet_samples;
        end
        if (state_reg == ST_READ)
        begin
            silent_reg <= slot_idx >= nch;
        end
    end

    // Output register
    always_comb
    begin
        if (load_hdr || load_smp)
        begin
            out_valid_next = 1'b1;
        end
        else if (pkt.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_hdr)
        begin
            out_data_reg  <= header_word;
            out_bytes_reg <= NB_HEADER;
            is_header_reg <= 1'b1;
            last_reg      <= !complete_reg;
        end
        else if (load_smp)
        begin
            out_data_reg  <= sample_word;
            out_bytes_reg <= sample_bytes;
            is_header_reg <= 1'b0;
            last_reg      <= last_slot;
        end
    end

    assign pkt.valid       = out_valid_reg;
    assign pkt.out_data    = out_data_reg;
    assign pkt.out_bytes   = out_bytes_reg;
    assign pkt.is_header   = is_header_reg;
    assign pkt.last_of_run = last_reg;

endmodule
